// File: design/sensor_frame_receiver_macros.svh
// Assertion macros for the sensor frame receiver.
// Used by the top level; needs no other file.
`ifndef SENSOR_FRAME_RECEIVER_MACROS_SVH
`define SENSOR_FRAME_RECEIVER_MACROS_SVH

`ifndef ASSERT_OFF
// ante implies cons in the same cycle
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sfr assertion failed");
// ante implies cons in the next cycle
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sfr assertion failed");
`else
`define SFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: design/sfr_pkg.sv
// Types and constants shared by the sensor frame receiver modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

  typedef enum logic [2:0] {
    REG_HEADER = 3'd0,
    REG_LENGTH = 3'd1,
    REG_SKIP   = 3'd2,
    REG_ORIGIN = 3'd3,
    REG_TS_EN  = 3'd4
  } reg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [7:0]  HeaderRst = 8'd194;
  localparam logic [7:0]  LengthRst = 8'd31;
  localparam logic [15:0] SkipRst   = 16'd1000;
  localparam logic [31:0] OriginRst = 32'd0;
  localparam logic        TsEnRst   = 1'b1;

  localparam int unsigned MinFrameLen = 7;
  localparam int unsigned IndexReach  = 128;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  frame_length;
    logic [15:0] skip_limit;
    logic        ts_en;
  } front_cfg_t;

  typedef struct packed {
    logic        origin_wr;
    logic [31:0] tick_origin;
  } back_cfg_t;

  // classified frame byte, front to back
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [6:0]  byte_index;
    logic        eof;
    logic        good;
    logic        forced;
    logic        ext_req;
    logic [31:0] ticks;
  } entry_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [6:0]  byte_index;
    logic        end_of_frame;
    logic        checksum_good;
    logic        header_forced;
    logic        ticks_valid;
    logic [63:0] extended_ticks;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage
`default_nettype wire

// File: design/sfr_rx_if.sv
// Byte input channel of the sensor frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: design/sfr_frame_if.sv
// Frame byte output channel of the sensor frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface sfr_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic [6:0]  byte_index;
  logic        end_of_frame;
  logic        checksum_good;
  logic        header_forced;
  logic        ticks_valid;
  logic [63:0] extended_ticks;

  modport source (output valid, output frame_byte, output byte_index, output end_of_frame,
                  output checksum_good, output header_forced, output ticks_valid,
                  output extended_ticks, input ready);
  modport sink   (input valid, input frame_byte, input byte_index, input end_of_frame,
                  input checksum_good, input header_forced, input ticks_valid,
                  input extended_ticks, output ready);
endinterface
`default_nettype wire

// File: design/sfr_front.sv
// Front end: header hunt, frame position, checksum and tick capture.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfr_front #(
  parameter int unsigned MaxFrame = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sfr_pkg::front_cfg_t cfg_i,
  input  wire logic               acc_i,
  input  wire logic [7:0]         byte_i,
  output logic                    push_o,
  output sfr_pkg::entry_t         entry_o
);

  localparam int unsigned LenTop  =
      (MaxFrame > sfr_pkg::IndexReach) ? sfr_pkg::IndexReach : MaxFrame;
  localparam logic [7:0] LenTopB = 8'(LenTop);
  localparam logic [7:0] LenMinB = 8'(sfr_pkg::MinFrameLen);

  logic        in_frame_q, in_frame_d;
  logic [15:0] skip_q, skip_d;
  logic [6:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  trl_q, trl_d;
  logic [31:0] tick_q, tick_d;
  logic        forced_q, forced_d;

  logic [7:0]  len, pos8;
  logic [16:0] cnt;
  logic [15:0] lim;
  logic        start;

  always_comb begin
    priority if (cfg_i.frame_length < LenMinB) begin
      len = LenMinB;
    end else if (cfg_i.frame_length > LenTopB) begin
      len = LenTopB;
    end else begin
      len = cfg_i.frame_length;
    end
  end

  assign pos8 = {1'b0, pos_q};
  assign cnt  = {1'b0, skip_q} + 17'd1;
  assign lim  = (cfg_i.skip_limit == 16'd0) ? 16'd1 : cfg_i.skip_limit;

  always_comb begin
    in_frame_d = in_frame_q;
    skip_d     = skip_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    trl_d      = trl_q;
    tick_d     = tick_q;
    forced_d   = forced_q;
    start      = 1'b0;
    push_o     = 1'b0;
    entry_o    = '0;
    entry_o.frame_byte = byte_i;

    if (acc_i) begin
      if (!in_frame_q) begin
        priority if (byte_i == cfg_i.header_byte) begin
          start    = 1'b1;
          forced_d = 1'b0;
        end else if (cnt >= {1'b0, lim}) begin
          start    = 1'b1;
          forced_d = 1'b1;
        end else begin
          skip_d = cnt[15:0];
        end
        if (start) begin
          in_frame_d = 1'b1;
          skip_d     = '0;
          pos_d      = 7'd1;
          sum_d      = {8'd0, byte_i};
          tick_d     = '0;
          trl_d      = '0;
          push_o     = 1'b1;
          entry_o.forced = forced_d;
        end
      end else begin
        push_o             = 1'b1;
        entry_o.byte_index = pos_q;
        entry_o.forced     = forced_q;
        if (pos8 >= len - 8'd1) begin
          entry_o.eof     = 1'b1;
          entry_o.good    = (sum_q == {trl_q, byte_i});
          entry_o.ext_req = (sum_q == {trl_q, byte_i}) && cfg_i.ts_en;
          entry_o.ticks   = tick_q;
          in_frame_d      = 1'b0;
          pos_d           = '0;
          forced_d        = 1'b0;
        end else begin
          if (pos8 <= len - 8'd3) begin
            sum_d = sum_q + {8'd0, byte_i};
          end
          // four tick bytes sit just before the trailer
          if (pos8 >= len - 8'd6 && pos8 <= len - 8'd3) begin
            tick_d = {tick_q[23:0], byte_i};
          end
          if (pos8 == len - 8'd2) begin
            trl_d = byte_i;
          end
          pos_d = pos_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      skip_q     <= '0;
      pos_q      <= '0;
      sum_q      <= '0;
      trl_q      <= '0;
      tick_q     <= '0;
      forced_q   <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      skip_q     <= skip_d;
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      trl_q      <= trl_d;
      tick_q     <= tick_d;
      forced_q   <= forced_d;
    end
  end

endmodule
`default_nettype wire

// File: design/sfr_queue.sv
// Short queue between front and back end.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfr_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire sfr_pkg::entry_t       data_i,
  input  wire logic                  pop_i,
  output sfr_pkg::entry_t            data_o,
  output sfr_pkg::queue_status_t     status_o
);

  localparam int unsigned CntW = sfr_pkg::QPtrW + 1;

  sfr_pkg::entry_t            mem_q [sfr_pkg::QueueDepth];
  logic [sfr_pkg::QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]            cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CntW'(sfr_pkg::QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign data_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// File: design/sfr_back.sv
// Back end: wrap tracking, tick extension and the output register.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfr_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sfr_pkg::back_cfg_t cfg_i,
  input  wire logic               entry_valid_i,
  input  wire sfr_pkg::entry_t    entry_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  output sfr_pkg::result_t        res_o,
  input  wire logic               res_ready_i
);

  logic             valid_q, valid_d;
  sfr_pkg::result_t res_q, res_d;
  logic [31:0]      wrap_q, wrap_d, prev_q, prev_d, wrap_new;

  assign pop_o       = entry_valid_i && (!valid_q || res_ready_i);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  assign wrap_new = (entry_i.ticks < prev_q) ? wrap_q + 32'd1 : wrap_q;

  always_comb begin
    wrap_d  = wrap_q;
    prev_d  = prev_q;
    res_d   = res_q;
    valid_d = valid_q && !res_ready_i;

    if (cfg_i.origin_wr) begin
      wrap_d = '0;
      prev_d = cfg_i.tick_origin;
    end else if (pop_o) begin
      valid_d              = 1'b1;
      res_d.frame_byte     = entry_i.frame_byte;
      res_d.byte_index     = entry_i.byte_index;
      res_d.end_of_frame   = entry_i.eof;
      res_d.checksum_good  = entry_i.good;
      res_d.header_forced  = entry_i.forced;
      res_d.ticks_valid    = entry_i.ext_req;
      res_d.extended_ticks = '0;
      if (entry_i.ext_req) begin
        wrap_d = wrap_new;
        prev_d = entry_i.ticks;
        res_d.extended_ticks = {wrap_new, entry_i.ticks} - {32'd0, cfg_i.tick_origin};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wrap_q  <= '0;
      prev_q  <= sfr_pkg::OriginRst;
    end else begin
      valid_q <= valid_d;
      wrap_q  <= wrap_d;
      prev_q  <= prev_d;
    end
  end

endmodule
`default_nettype wire

// File: design/sensor_frame_receiver.sv
// Sensor frame receiver: header hunt, 16-bit additive checksum, tick extension.
// Rate: one byte per cycle while the queue has room, set by the front end's combinational classification.
// Channels: rx_i takes one serial byte per item (valid/ready). frame_o gives
//   one item per frame byte; bytes dropped while hunting for the header give
//   none. Each item carries the byte, its index (header is 0), and on the last
//   byte the checksum verdict and, when enabled and the checksum is good, the 64-bit extended ticks.
// Config: cfg_we_i/cfg_idx_i/cfg_wdata_i write registers 0..4 (header,
//   length, skip limit, tick origin, timestamp enable); write only while idle.
//   Writing the tick origin also clears the wrap count.
// Path: a byte accepted on rx_i is written into the queue, then into the back end
//   output register, from which it shows on frame_o.
// Throughput: one item per cycle while frame_o takes its items; rx_i stays ready while the
//   two-entry queue has room, so it keeps taking bytes while a result waits.
// Stall: when frame_o is not taken, the back end holds its output register,
//   the queue fills, and rx_i drops ready after two more items.
// Reset: asynchronous, active low; registers take their defaults, hunt mode,
//   wrap count and previous ticks cleared. No clearing pass.
// Depends on sfr_pkg, sfr_rx_if, sfr_frame_if, sfr_front, sfr_queue, sfr_back
//   and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "sensor_frame_receiver_macros.svh"
module sensor_frame_receiver #(
  parameter int unsigned MAX_FRAME = 128
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  sfr_rx_if.sink                             rx_i,
  sfr_frame_if.source                        frame_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sfr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sfr_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  // configuration registers
  logic [7:0]  header_q, length_q;
  logic [15:0] skip_q;
  logic [31:0] origin_q;
  logic        ts_en_q;

  sfr_pkg::front_cfg_t    front_cfg;
  sfr_pkg::back_cfg_t     back_cfg;
  sfr_pkg::entry_t        push_entry, head_entry;
  sfr_pkg::queue_status_t q_status;
  sfr_pkg::result_t       res;
  logic                   rx_acc, push, pop, res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= sfr_pkg::HeaderRst;
      length_q <= sfr_pkg::LengthRst;
      skip_q   <= sfr_pkg::SkipRst;
      origin_q <= sfr_pkg::OriginRst;
      ts_en_q  <= sfr_pkg::TsEnRst;
    end else if (cfg_we_i) begin
      unique case (sfr_pkg::reg_idx_e'(cfg_idx_i))
        sfr_pkg::REG_HEADER: header_q <= cfg_wdata_i[7:0];
        sfr_pkg::REG_LENGTH: length_q <= cfg_wdata_i[7:0];
        sfr_pkg::REG_SKIP:   skip_q   <= cfg_wdata_i[15:0];
        sfr_pkg::REG_ORIGIN: origin_q <= cfg_wdata_i[31:0];
        sfr_pkg::REG_TS_EN:  ts_en_q  <= cfg_wdata_i[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  assign front_cfg.header_byte  = header_q;
  assign front_cfg.frame_length = length_q;
  assign front_cfg.skip_limit   = skip_q;
  assign front_cfg.ts_en        = ts_en_q;

  // origin write restarts wrap tracking in the back end; on the write cycle
  // the new origin goes straight through, otherwise the stored one is used
  assign back_cfg.origin_wr   = cfg_we_i &&
                                (sfr_pkg::reg_idx_e'(cfg_idx_i) == sfr_pkg::REG_ORIGIN);
  assign back_cfg.tick_origin = back_cfg.origin_wr ? cfg_wdata_i[31:0] : origin_q;

  assign rx_i.ready = !q_status.full;
  assign rx_acc     = rx_i.valid && rx_i.ready;

  sfr_front #(
    .MaxFrame (MAX_FRAME)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (front_cfg),
    .acc_i   (rx_acc),
    .byte_i  (rx_i.rx_byte),
    .push_o  (push),
    .entry_o (push_entry)
  );

  sfr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_entry),
    .pop_i    (pop),
    .data_o   (head_entry),
    .status_o (q_status)
  );

  sfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (back_cfg),
    .entry_valid_i (!q_status.empty),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_ready_i   (frame_o.ready)
  );

  assign frame_o.valid          = res_valid;
  assign frame_o.frame_byte     = res.frame_byte;
  assign frame_o.byte_index     = res.byte_index;
  assign frame_o.end_of_frame   = res.end_of_frame;
  assign frame_o.checksum_good  = res.checksum_good;
  assign frame_o.header_forced  = res.header_forced;
  assign frame_o.ticks_valid    = res.ticks_valid;
  assign frame_o.extended_ticks = res.extended_ticks;

  // verdict fields only on the last byte; extension implies a good checksum
  `SFR_ASSERT_IMP(a_mid_clean, clk_i, rst_ni, res_valid && !res.end_of_frame, !res.checksum_good && !res.ticks_valid)
  `SFR_ASSERT_IMP(a_ext_good, clk_i, rst_ni, res_valid && res.ticks_valid, res.checksum_good)
  `SFR_ASSERT_IMP(a_ext_zero, clk_i, rst_ni, res_valid && !res.ticks_valid, res.extended_ticks == 64'd0)
  // a byte taken from an empty queue would be a lost or invented item
  `SFR_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop, !q_status.empty)
  `SFR_ASSERT_NXT(a_push_fill, clk_i, rst_ni, push && !pop, !q_status.empty)

endmodule
`default_nettype wire
